// ===== hdl/angle_bias_kalman_filter_top_macros.svh =====
// ---------------------------------------------------------------------------
// angle_bias_kalman_filter_top_macros.svh
// Assertion macros for the angle and gyro bias Kalman filter.
// ---------------------------------------------------------------------------
`ifndef ANGLE_BIAS_KALMAN_FILTER_TOP_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_TOP_MACROS_SVH

// Checked only while out of reset.
`define ABKF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ABKF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/abkf_pkg.sv =====
// ---------------------------------------------------------------------------
// abkf_pkg
// Types, constants and helpers shared by the Kalman filter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package abkf_pkg;

    localparam int MulW  = 36;          // signed operand width of the multiplier
    localparam int ProdW = 2 * MulW;    // full product width
    localparam int FracW = 24;          // Q8.24 fraction bits
    localparam int RndW  = ProdW - FracW;
    localparam int QW    = 32 + FracW;  // quotient width of the divider
    localparam int SumW  = QW + 1;      // width used for saturating sums

    localparam logic signed [SumW-1:0] SatMax = SumW'(64'sd2147483647);
    localparam logic signed [SumW-1:0] SatMin = SumW'(-64'sd2147483648);

    localparam logic signed [31:0] StartAngleRst   = 32'sd0;
    localparam logic [30:0]        AngleNoiseRst   = 31'd16777;
    localparam logic [30:0]        BiasNoiseRst    = 31'd50332;
    localparam logic [30:0]        MeasureNoiseRst = 31'd503316;

    typedef enum logic [1:0] {
        CFG_START_ANGLE,
        CFG_ANGLE_NOISE,
        CFG_BIAS_NOISE,
        CFG_MEASURE_NOISE
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] gyro_dps;
        logic [23:0]        time_step;
        logic signed [31:0] accel_angle;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] bias_estimate;
        logic               skipped;
        logic               saturated;
    } t_out_beat;

    typedef struct packed {
        logic                  start;
        logic signed [MulW-1:0] a;
        logic signed [MulW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                   done;
        logic signed [RndW-1:0] res;
    } t_mul_rsp;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] k;
        logic               ovf;
    } t_div_rsp;

    typedef enum logic [2:0] {M_IDLE, M_RUN, M_NEG, M_RND, M_DONE} t_mul_state;
    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX, D_DONE} t_div_state;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RATE, ST_DTP, ST_P00, ST_K0, ST_K1, ST_ANG, ST_BIAS,
        ST_CAA, ST_CAB, ST_CBA, ST_CBB, ST_DONE
    } t_kf_state;

    function automatic logic signed [31:0] sat_val(input logic signed [SumW-1:0] v);
        logic signed [31:0] r;
        if (v > SatMax) begin
            r = 32'sh7fffffff;
        end else if (v < SatMin) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic sat_ovf(input logic signed [SumW-1:0] v);
        return (v > SatMax) || (v < SatMin);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/abkf_mul.sv =====
// ---------------------------------------------------------------------------
// abkf_mul
// Bit-serial signed multiplier with Q8.24 rounding of the product.
// ---------------------------------------------------------------------------
`default_nettype none

module abkf_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire abkf_pkg::t_mul_req i_req,
    output abkf_pkg::t_mul_rsp      o_rsp
);
    import abkf_pkg::*;

    localparam logic [5:0]             CntLast   = 6'(MulW - 1);
    localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(64'sd8388608);

    t_mul_state r_state, n_state;
    logic [5:0]              r_cnt;
    logic                    r_neg;
    logic [MulW-1:0]         r_mcand;
    logic [ProdW-1:0]        r_acc;
    logic signed [RndW-1:0]  r_res;

    logic [MulW-1:0]         a_mag, b_mag;
    logic [MulW:0]           step_sum;
    logic signed [ProdW-1:0] rnd_sum;

    assign a_mag    = i_req.a[MulW-1] ? MulW'(-i_req.a) : MulW'(i_req.a);
    assign b_mag    = i_req.b[MulW-1] ? MulW'(-i_req.b) : MulW'(i_req.b);
    assign step_sum = {1'b0, r_acc[ProdW-1:MulW]} + (r_acc[0] ? {1'b0, r_mcand} : '0);
    assign rnd_sum  = $signed(r_acc) + RoundHalf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            M_IDLE: if (i_req.start) n_state = M_RUN;
            M_RUN:  if (r_cnt == CntLast) n_state = M_NEG;
            M_NEG:  n_state = M_RND;
            M_RND:  n_state = M_DONE;
            M_DONE: n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    // The multiplier bits sit in the low half of the accumulator and shift
    // out one per cycle while the partial sum grows into the high half.
    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    r_neg   <= i_req.a[MulW-1] ^ i_req.b[MulW-1];
                    r_mcand <= a_mag;
                    r_acc   <= {{MulW{1'b0}}, b_mag};
                    r_cnt   <= '0;
                end
            end
            M_RUN: begin
                r_acc <= {step_sum, r_acc[MulW-1:1]};
                r_cnt <= r_cnt + 6'd1;
            end
            M_NEG: if (r_neg) r_acc <= -r_acc;
            M_RND: r_res <= rnd_sum[ProdW-1:FracW];
            default: ;
        endcase
    end

    assign o_rsp.done = (r_state == M_DONE);
    assign o_rsp.res  = r_res;

endmodule

`default_nettype wire

// ===== hdl/abkf_div.sv =====
// ---------------------------------------------------------------------------
// abkf_div
// Restoring divider for the gains, one quotient bit per cycle, saturated.
// ---------------------------------------------------------------------------
`default_nettype none

module abkf_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire abkf_pkg::t_div_req i_req,
    output abkf_pkg::t_div_rsp      o_rsp
);
    import abkf_pkg::*;

    localparam logic [5:0] CntLast = 6'(QW - 1);

    t_div_state r_state, n_state;
    logic [5:0]         r_cnt;
    logic               r_neg;
    logic [32:0]        r_den;
    logic [31:0]        r_rem;
    logic [QW-1:0]      r_q;
    logic signed [31:0] r_k;
    logic               r_ovf;

    logic [31:0]           num_mag;
    logic [32:0]           den_mag;
    logic [33:0]           trial;
    logic signed [SumW-1:0] q_signed;

    assign num_mag  = i_req.num[31] ? 32'(-i_req.num) : 32'(i_req.num);
    assign den_mag  = i_req.den[32] ? 33'(-i_req.den) : 33'(i_req.den);
    assign trial    = {1'b0, r_rem, r_q[QW-1]} - {1'b0, r_den};
    assign q_signed = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE: if (i_req.start) n_state = D_RUN;
            D_RUN:  if (r_cnt == CntLast) n_state = D_FIX;
            D_FIX:  n_state = D_DONE;
            D_DONE: n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    // The dividend shifts out of the quotient register as quotient bits
    // shift in; the quotient truncates toward zero on the magnitudes.
    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_req.start) begin
                    r_neg <= i_req.num[31] ^ i_req.den[32];
                    r_den <= den_mag;
                    r_rem <= '0;
                    r_q   <= {num_mag, {FracW{1'b0}}};
                    r_cnt <= '0;
                end
            end
            D_RUN: begin
                if (!trial[33]) begin
                    r_rem <= trial[31:0];
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[30:0], r_q[QW-1]};
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
            end
            D_FIX: begin
                r_k   <= sat_val(q_signed);
                r_ovf <= sat_ovf(q_signed);
            end
            default: ;
        endcase
    end

    assign o_rsp.done = (r_state == D_DONE);
    assign o_rsp.k    = r_k;
    assign o_rsp.ovf  = r_ovf;

endmodule

`default_nettype wire

// ===== hdl/angle_bias_kalman_filter_top.sv =====
// ---------------------------------------------------------------------------
// angle_bias_kalman_filter_top
// Two-state Kalman filter for angle and gyro bias, Q16.16 / Q8.24 fixed point.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                  Beat
// in        input      i_in_valid / o_in_stall    t_in_beat
// out       output     o_out_valid / i_out_stall  t_out_beat
// cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A sample runs nine products on the shared bit-serial multiplier and, unless
// the innovation variance is zero, two gains on the bit-serial divider. A zero
// time step goes straight from idle to the result state.
// Reset is synchronous and needs no clearing pass. A new beat is taken while
// the previous result still waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "angle_bias_kalman_filter_top_macros.svh"

module angle_bias_kalman_filter_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire abkf_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output abkf_pkg::t_out_beat      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data
);
    import abkf_pkg::*;

    t_kf_state r_state, n_state;
    logic r_launch;

    logic signed [31:0] r_start;
    logic [30:0]        r_anoise, r_bnoise, r_mnoise;
    logic signed [31:0] r_angle, r_bias, r_caa, r_cab, r_cba, r_cbb;
    logic signed [31:0] r_gyro, r_meas;
    logic [23:0]        r_dt;
    logic signed [31:0] r_dtp, r_p00, r_p01, r_p10, r_p11, r_k0, r_k1;
    logic signed [32:0] r_y;
    logic               r_sat, r_skip;
    logic               r_out_valid;
    t_out_beat          r_out;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic signed [32:0]     rate, y_now, s_val;
    logic signed [MulW-1:0] sum_p00, dt_ext;
    logic signed [SumW-1:0] t_ext;
    logic signed [SumW-1:0] sum_ang, sum_p00v, sum_p01, sum_p10, sum_p11;
    logic signed [SumW-1:0] sum_bias, sum_caa, sum_cab, sum_cba, sum_cbb;
    logic                   s_zero, out_free, in_accept;
    logic signed [31:0]     start_next;

    abkf_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req), .o_rsp(mul_rsp));
    abkf_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    assign rate    = 33'(r_gyro) - 33'(r_bias);
    assign y_now   = 33'(r_meas) - 33'(r_angle);
    assign s_val   = 33'(r_p00) + 33'({1'b0, r_mnoise});
    assign s_zero  = (s_val == '0);
    assign dt_ext  = MulW'({1'b0, r_dt});
    assign sum_p00 = MulW'(r_dtp) - MulW'(r_cab) - MulW'(r_cba) + MulW'({1'b0, r_anoise});

    assign t_ext    = SumW'($signed(mul_rsp.res));
    assign sum_ang  = SumW'(r_angle) + t_ext;
    assign sum_bias = SumW'(r_bias) + t_ext;
    assign sum_p00v = SumW'(r_caa) + t_ext;
    assign sum_p01  = SumW'(r_cab) - SumW'(r_dtp);
    assign sum_p10  = SumW'(r_cba) - SumW'(r_dtp);
    assign sum_p11  = SumW'(r_cbb) + SumW'({1'b0, r_bnoise});
    assign sum_caa  = SumW'(r_p00) - t_ext;
    assign sum_cab  = SumW'(r_p01) - t_ext;
    assign sum_cba  = SumW'(r_p10) - t_ext;
    assign sum_cbb  = SumW'(r_p11) - t_ext;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign start_next  = (t_cfg_idx'(i_cfg_idx) == CFG_START_ANGLE) ? i_cfg_data : r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_stall    = (r_state != ST_IDLE);
        mul_req       = '0;
        mul_req.start = r_launch;
        div_req       = '0;
        div_req.den   = s_val;
        case (r_state)
            ST_IDLE: begin
                mul_req.start = 1'b0;
                if (i_in_valid) begin
                    n_state = (i_in_data.time_step == '0) ? ST_DONE : ST_RATE;
                end
            end
            ST_RATE: begin
                mul_req.a = MulW'(rate);
                mul_req.b = dt_ext;
                if (mul_rsp.done) n_state = ST_DTP;
            end
            ST_DTP: begin
                mul_req.a = MulW'(r_cbb);
                mul_req.b = dt_ext;
                if (mul_rsp.done) n_state = ST_P00;
            end
            ST_P00: begin
                mul_req.a = sum_p00;
                mul_req.b = dt_ext;
                if (mul_rsp.done) n_state = ST_K0;
            end
            ST_K0: begin
                mul_req.start = 1'b0;
                div_req.num   = r_p00;
                if (r_launch && s_zero) begin
                    n_state = ST_ANG;
                end else begin
                    div_req.start = r_launch;
                    if (div_rsp.done) n_state = ST_K1;
                end
            end
            ST_K1: begin
                mul_req.start = 1'b0;
                div_req.start = r_launch;
                div_req.num   = r_p10;
                if (div_rsp.done) n_state = ST_ANG;
            end
            ST_ANG: begin
                mul_req.a = MulW'(r_k0);
                mul_req.b = MulW'(y_now);
                if (mul_rsp.done) n_state = ST_BIAS;
            end
            ST_BIAS: begin
                mul_req.a = MulW'(r_k1);
                mul_req.b = MulW'(r_y);
                if (mul_rsp.done) n_state = ST_CAA;
            end
            ST_CAA: begin
                mul_req.a = MulW'(r_k0);
                mul_req.b = MulW'(r_p00);
                if (mul_rsp.done) n_state = ST_CAB;
            end
            ST_CAB: begin
                mul_req.a = MulW'(r_k0);
                mul_req.b = MulW'(r_p01);
                if (mul_rsp.done) n_state = ST_CBA;
            end
            ST_CBA: begin
                mul_req.a = MulW'(r_k1);
                mul_req.b = MulW'(r_p00);
                if (mul_rsp.done) n_state = ST_CBB;
            end
            ST_CBB: begin
                mul_req.a = MulW'(r_k1);
                mul_req.b = MulW'(r_p01);
                if (mul_rsp.done) n_state = ST_DONE;
            end
            ST_DONE: begin
                mul_req.start = 1'b0;
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                mul_req.start = 1'b0;
                n_state       = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
            r_start     <= StartAngleRst;
            r_anoise    <= AngleNoiseRst;
            r_bnoise    <= BiasNoiseRst;
            r_mnoise    <= MeasureNoiseRst;
            r_angle     <= StartAngleRst;
            r_bias      <= '0;
            r_caa       <= '0;
            r_cab       <= '0;
            r_cba       <= '0;
            r_cbb       <= '0;
        end else begin
            r_launch <= (n_state != r_state);

            // A finished result replaces a beat taken at the same edge.
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // Any register write also restarts the filter state.
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_START_ANGLE:   r_start  <= i_cfg_data;
                    CFG_ANGLE_NOISE:   r_anoise <= i_cfg_data[30:0];
                    CFG_BIAS_NOISE:    r_bnoise <= i_cfg_data[30:0];
                    CFG_MEASURE_NOISE: r_mnoise <= i_cfg_data[30:0];
                    default: ;
                endcase
                r_angle <= start_next;
                r_bias  <= '0;
                r_caa   <= '0;
                r_cab   <= '0;
                r_cba   <= '0;
                r_cbb   <= '0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_gyro <= i_in_data.gyro_dps;
                        r_dt   <= i_in_data.time_step;
                        r_meas <= i_in_data.accel_angle;
                        r_skip <= (i_in_data.time_step == '0);
                        r_sat  <= 1'b0;
                    end
                end
                ST_RATE: begin
                    if (mul_rsp.done) begin
                        r_angle <= sat_val(sum_ang);
                        r_sat   <= r_sat | sat_ovf(sum_ang);
                    end
                end
                ST_DTP: if (mul_rsp.done) r_dtp <= mul_rsp.res[31:0];
                ST_P00: begin
                    if (mul_rsp.done) begin
                        r_p00 <= sat_val(sum_p00v);
                        r_p01 <= sat_val(sum_p01);
                        r_p10 <= sat_val(sum_p10);
                        r_p11 <= sat_val(sum_p11);
                        r_sat <= r_sat | sat_ovf(sum_p00v) | sat_ovf(sum_p01)
                               | sat_ovf(sum_p10) | sat_ovf(sum_p11);
                    end
                end
                ST_K0: begin
                    // A zero innovation variance forces both gains to zero.
                    if (r_launch && s_zero) begin
                        r_k0  <= '0;
                        r_k1  <= '0;
                        r_sat <= 1'b1;
                    end else if (div_rsp.done) begin
                        r_k0  <= div_rsp.k;
                        r_sat <= r_sat | div_rsp.ovf;
                    end
                end
                ST_K1: begin
                    if (div_rsp.done) begin
                        r_k1  <= div_rsp.k;
                        r_sat <= r_sat | div_rsp.ovf;
                    end
                end
                ST_ANG: begin
                    if (r_launch) r_y <= y_now;
                    if (mul_rsp.done) begin
                        r_angle <= sat_val(sum_ang);
                        r_sat   <= r_sat | sat_ovf(sum_ang);
                    end
                end
                ST_BIAS: begin
                    if (mul_rsp.done) begin
                        r_bias <= sat_val(sum_bias);
                        r_sat  <= r_sat | sat_ovf(sum_bias);
                    end
                end
                ST_CAA: begin
                    if (mul_rsp.done) begin
                        r_caa <= sat_val(sum_caa);
                        r_sat <= r_sat | sat_ovf(sum_caa);
                    end
                end
                ST_CAB: begin
                    if (mul_rsp.done) begin
                        r_cab <= sat_val(sum_cab);
                        r_sat <= r_sat | sat_ovf(sum_cab);
                    end
                end
                ST_CBA: begin
                    if (mul_rsp.done) begin
                        r_cba <= sat_val(sum_cba);
                        r_sat <= r_sat | sat_ovf(sum_cba);
                    end
                end
                ST_CBB: begin
                    if (mul_rsp.done) begin
                        r_cbb <= sat_val(sum_cbb);
                        r_sat <= r_sat | sat_ovf(sum_cbb);
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out.angle_estimate <= r_angle;
                        r_out.bias_estimate  <= r_bias;
                        r_out.skipped        <= r_skip;
                        r_out.saturated      <= r_sat;
                    end
                end
                default: ;
            endcase
        end
    end

    `ABKF_ASSERT(a_skip_path, (in_accept && i_in_data.time_step == '0) |=> (r_state == ST_DONE && r_skip), "zero time step did not go straight to the result")
    `ABKF_ASSERT(a_result_held, (r_state == ST_DONE && r_out_valid && i_out_stall) |=> (r_state == ST_DONE), "finished result overwrote a waiting beat")
    `ABKF_ASSERT(a_idle_quiet, (r_state == ST_IDLE) |-> (!mul_rsp.done && !div_rsp.done), "arithmetic unit finished while the filter was idle")
    `ABKF_ASSERT_ALWAYS(a_reset_out, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

`default_nettype wire
